>>> sv/hwpc_pkg.sv
// types, codes and constants shared by the host watchdog power cycler
// no dependencies

package hwpc_pkg;

	localparam logic [7:0] WDT_ENABLE_MAGIC = 8'h63;
	localparam logic [7:0] CMD_CLEAR = 8'h01;
	localparam logic [7:0] CMD_RESET = 8'h11;
	localparam logic [7:0] CMD_CYCLE = 8'h21;

	localparam logic [15:0] TIMER_LIMIT_RST = 16'd3600;
	localparam logic [7:0] CYCLE_DELAY_RST = 8'd30;

	localparam int IN_TDATA_W = 32;
	localparam int OUT_TDATA_W = 48;

	typedef enum logic [1:0] {
		ACT_TICK = 2'd0,
		ACT_CMD = 2'd1,
		ACT_TIMER_WR = 2'd2,
		ACT_SAVE_DONE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		CFG_WDT_ENABLE = 2'd0,
		CFG_TIMER_LIMIT = 2'd1,
		CFG_CYCLE_DELAY = 2'd2,
		CFG_COUNT_INIT = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0] wdt_enable_code;
		logic [15:0] timer_limit;
		logic [7:0] cycle_delay;
	} cfg_t;

	typedef struct packed {
		logic [15:0] reset_timer;
		logic [15:0] reset_count;
		logic cycle_pending;
		logic [7:0] cycle_countdown;
		logic [1:0] bytes_to_save;
		logic [4:0] link_error_countdown;
		logic shutdown_latched;
	} state_t;

	typedef struct packed {
		action_t action;
		logic [7:0] command;
		logic [15:0] timer_value;
		logic link_error;
	} event_t;

	typedef struct packed {
		logic cycle_pending_out;
		logic [15:0] reset_count_value;
		logic [15:0] reset_timer_value;
		logic [7:0] save_data;
		logic save_byte_index;
		logic save_pending;
		logic mcu_reset;
		logic shutdown;
	} result_t;

endpackage

>>> sv/hwpc_step.sv
// next-state and result logic for one event of the host watchdog power cycler
// depends on hwpc_pkg

module hwpc_step
	import hwpc_pkg::*;
#(
	parameter logic [4:0] LINK_ERROR_SECONDS = 5'd25,
	parameter logic [7:0] SAVE_GRACE_SECONDS = 8'd10
) (
	input cfg_t cfg,
	input state_t state,
	input event_t evt,
	output state_t state_next,
	output result_t result
);

	logic pulse;
	logic saving;
	logic idx;

	always_comb begin
		state_next = state;
		pulse = 1'b0;
		unique case (evt.action)
			ACT_TICK: begin
				if (cfg.wdt_enable_code == WDT_ENABLE_MAGIC) begin
					if (state.reset_timer >= cfg.timer_limit) begin
						if (!state.cycle_pending) begin
							state_next.reset_count = state.reset_count + 16'd1;
							state_next.cycle_pending = 1'b1;
							state_next.cycle_countdown = SAVE_GRACE_SECONDS;
							state_next.bytes_to_save = 2'd2;
						end
					end else begin
						state_next.reset_timer = state.reset_timer + 16'd1;
					end
				end
				if (state_next.cycle_pending) begin
					if (state_next.cycle_countdown != 8'd0)
						state_next.cycle_countdown = state_next.cycle_countdown - 8'd1;
					if (state_next.cycle_countdown == 8'd0)
						state_next.shutdown_latched = 1'b1;
				end
				if (evt.link_error) begin
					if (state.link_error_countdown != 5'd0)
						state_next.link_error_countdown = state.link_error_countdown - 5'd1;
					else
						pulse = 1'b1;
				end else begin
					state_next.link_error_countdown = LINK_ERROR_SECONDS;
				end
			end
			ACT_CMD: begin
				if (!state.cycle_pending) begin
					unique case (evt.command)
						CMD_CLEAR: state_next.reset_timer = 16'd0;
						CMD_RESET: pulse = 1'b1;
						CMD_CYCLE: begin
							state_next.cycle_pending = 1'b1;
							state_next.cycle_countdown = cfg.cycle_delay;
							state_next.bytes_to_save = 2'd0;
						end
						default: ;
					endcase
				end
			end
			ACT_TIMER_WR: begin
				if (!state.cycle_pending)
					state_next.reset_timer = evt.timer_value;
			end
			ACT_SAVE_DONE: begin
				if (state.cycle_pending) begin
					unique case (state.bytes_to_save)
						2'd2, 2'd3: state_next.bytes_to_save = 2'd1;
						2'd1: begin
							state_next.bytes_to_save = 2'd0;
							state_next.cycle_countdown = 8'd0;
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase
	end

	assign saving = state_next.cycle_pending && (state_next.bytes_to_save != 2'd0);
	assign idx = saving && (state_next.bytes_to_save == 2'd1);

	always_comb begin
		result.shutdown = state_next.shutdown_latched;
		result.mcu_reset = pulse;
		result.save_pending = saving;
		result.save_byte_index = idx;
		if (!saving)
			result.save_data = 8'd0;
		else if (idx)
			result.save_data = state_next.reset_count[15:8];
		else
			result.save_data = state_next.reset_count[7:0];
		result.reset_timer_value = state_next.reset_timer;
		result.reset_count_value = state_next.reset_count;
		result.cycle_pending_out = state_next.cycle_pending;
	end

endmodule

>>> sv/host_watchdog_power_cycler.sv
// Host watchdog power cycler: takes one event beat (tick, host command, host timer
// write or save acknowledge) and returns one status beat per event. An event beat
// is taken every cycle unless the output stalls. It lands in the input register,
// the combinational update logic then fills the result register, and the status
// beat is offered from there. Output stalls hold the result register and push back
// on the input side.
// depends on hwpc_pkg and hwpc_step

module host_watchdog_power_cycler
	import hwpc_pkg::*;
#(
	parameter logic [4:0] LINK_ERROR_SECONDS = 5'd25,
	parameter logic [7:0] SAVE_GRACE_SECONDS = 8'd10
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_wdata,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// command[7:0], timer_value[23:8], link_error[24], zero pad
	input logic [IN_TDATA_W-1:0] s_axis_tdata,
	// action[1:0]
	input logic [1:0] s_axis_tuser,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// shutdown[0], mcu_reset[1], save_pending[2], save_byte_index[3], save_data[11:4],
	// reset_timer_value[27:12], reset_count_value[43:28], cycle_pending_out[44], zero pad
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	cfg_t cfg_q;
	state_t state_q;
	state_t state_next;
	event_t evt_s1;
	logic valid_s1;
	result_t result;
	result_t result_s2;
	logic valid_s2;
	logic advance;

	assign advance = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			evt_s1.action <= action_t'(s_axis_tuser);
			evt_s1.command <= s_axis_tdata[7:0];
			evt_s1.timer_value <= s_axis_tdata[23:8];
			evt_s1.link_error <= s_axis_tdata[24];
		end
	end

	hwpc_step #(
		.LINK_ERROR_SECONDS(LINK_ERROR_SECONDS),
		.SAVE_GRACE_SECONDS(SAVE_GRACE_SECONDS)
	) u_step (
		.cfg(cfg_q),
		.state(state_q),
		.evt(evt_s1),
		.state_next(state_next),
		.result(result)
	);

	// configuration and supervisor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wdt_enable_code <= 8'd0;
			cfg_q.timer_limit <= TIMER_LIMIT_RST;
			cfg_q.cycle_delay <= CYCLE_DELAY_RST;
			state_q.reset_timer <= 16'd0;
			state_q.reset_count <= 16'd0;
			state_q.cycle_pending <= 1'b0;
			state_q.cycle_countdown <= 8'd0;
			state_q.bytes_to_save <= 2'd0;
			state_q.link_error_countdown <= LINK_ERROR_SECONDS;
			state_q.shutdown_latched <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_WDT_ENABLE: cfg_q.wdt_enable_code <= cfg_wdata[7:0];
				CFG_TIMER_LIMIT: cfg_q.timer_limit <= cfg_wdata;
				CFG_CYCLE_DELAY: cfg_q.cycle_delay <= cfg_wdata[7:0];
				CFG_COUNT_INIT: state_q.reset_count <= cfg_wdata;
				default: ;
			endcase
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (!valid_s2 || m_axis_tready)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (advance)
			result_s2 <= result;
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata = {{(OUT_TDATA_W - $bits(result_t)){1'b0}}, result_s2};

endmodule

>>> sim/host_watchdog_power_cycler_test.sv
// testbench for host_watchdog_power_cycler: drives event beats, predicts each status beat
// with its own model of the watchdog, and compares every returned beat field by field
// depends on hwpc_pkg and the host_watchdog_power_cycler rtl
`timescale 1ns / 1ps

module host_watchdog_power_cycler_test;
	import hwpc_pkg::*;

	localparam logic [4:0] LINK_ERR_RELOAD = 5'd25;
	localparam logic [7:0] SAVE_GRACE = 8'd10;
	localparam int STALL_LIMIT = 2000;
	localparam int MAX_PRINTED = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_wdata = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic [1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	// configuration and state of the watchdog as predicted
	logic [7:0] en_code;
	logic [15:0] limit_s;
	logic [7:0] delay_s;
	logic [15:0] timer_s;
	logic [15:0] count_s;
	logic pending_s;
	logic [7:0] countdown_s;
	logic [1:0] save_left;
	logic [4:0] link_left;
	logic shut_s;

	result_t status_due[$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int error_count = 0;
	int events_taken = 0;
	int status_checked = 0;
	int pulses_due = 0;
	int stall_cycles = 0;
	bit link_down = 1'b0;
	string cycle_kind = "none";

	host_watchdog_power_cycler DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		m_axis_tready = ($urandom_range(0, 99) >= recv_idle_pct);
	end

	function automatic void reset_watchdog_model();
		en_code = 8'd0;
		limit_s = TIMER_LIMIT_RST;
		delay_s = CYCLE_DELAY_RST;
		timer_s = '0;
		count_s = '0;
		pending_s = 1'b0;
		countdown_s = '0;
		save_left = '0;
		link_left = LINK_ERR_RELOAD;
		shut_s = 1'b0;
	endfunction

	function automatic result_t watchdog_status(action_t act, logic [7:0] cmd,
			logic [15:0] tval, logic lerr);
		result_t r;
		logic pulse;
		pulse = 1'b0;
		case (act)
			ACT_TICK: begin
				if (en_code == WDT_ENABLE_MAGIC) begin
					if (timer_s >= limit_s) begin
						if (!pending_s) begin
							count_s = count_s + 16'd1;
							pending_s = 1'b1;
							countdown_s = SAVE_GRACE;
							save_left = 2'd2;
						end
					end else begin
						timer_s = timer_s + 16'd1;
					end
				end
				if (pending_s) begin
					if (countdown_s != 0)
						countdown_s = countdown_s - 8'd1;
					if (countdown_s == 0)
						shut_s = 1'b1;
				end
				if (lerr) begin
					if (link_left != 0)
						link_left = link_left - 5'd1;
					else
						pulse = 1'b1;
				end else begin
					link_left = LINK_ERR_RELOAD;
				end
			end
			ACT_CMD: begin
				if (!pending_s) begin
					if (cmd == CMD_CLEAR) begin
						timer_s = '0;
					end else if (cmd == CMD_RESET) begin
						pulse = 1'b1;
					end else if (cmd == CMD_CYCLE) begin
						pending_s = 1'b1;
						countdown_s = delay_s;
						save_left = 2'd0;
					end
				end
			end
			ACT_TIMER_WR: begin
				if (!pending_s)
					timer_s = tval;
			end
			default: begin
				if (pending_s) begin
					if (save_left >= 2'd2) begin
						save_left = 2'd1;
					end else if (save_left == 2'd1) begin
						save_left = 2'd0;
						countdown_s = '0;
					end
				end
			end
		endcase
		r = '0;
		r.shutdown = shut_s;
		r.mcu_reset = pulse;
		r.save_pending = pending_s && save_left != 0;
		if (r.save_pending) begin
			r.save_byte_index = (save_left == 2'd1);
			r.save_data = r.save_byte_index ? count_s[15:8] : count_s[7:0];
		end
		r.reset_timer_value = timer_s;
		r.reset_count_value = count_s;
		r.cycle_pending_out = pending_s;
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		error_count++;
		if (error_count <= MAX_PRINTED)
			$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	task automatic check_field(string name, int got, int want);
		if (got != want)
			report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	// status beats are checked before new events are predicted, since one edge can carry both
	always @(posedge clk) begin
		result_t got;
		result_t want;
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				moved = 1'b1;
				got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
				if (status_due.size() == 0) begin
					report_mismatch($sformatf("status beat %0h with none expected",
						m_axis_tdata));
				end else begin
					want = status_due.pop_front();
					status_checked++;
					check_field("shutdown", got.shutdown, want.shutdown);
					check_field("mcu_reset", got.mcu_reset, want.mcu_reset);
					check_field("save_pending", got.save_pending, want.save_pending);
					check_field("save_byte_index", got.save_byte_index,
						want.save_byte_index);
					check_field("save_data", got.save_data, want.save_data);
					check_field("reset_timer_value", got.reset_timer_value,
						want.reset_timer_value);
					check_field("reset_count_value", got.reset_count_value,
						want.reset_count_value);
					check_field("cycle_pending_out", got.cycle_pending_out,
						want.cycle_pending_out);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				moved = 1'b1;
				want = watchdog_status(action_t'(s_axis_tuser), s_axis_tdata[7:0],
					s_axis_tdata[23:8], s_axis_tdata[24]);
				status_due.push_back(want);
				events_taken++;
				if (want.mcu_reset)
					pulses_due++;
			end
			stall_cycles = moved ? 0 : stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// called and returns at a falling edge
	task automatic send_event(action_t act, logic [7:0] cmd, logic [15:0] tval, logic lerr);
		while ($urandom_range(0, 99) < send_idle_pct)
			@(negedge clk);
		s_axis_tuser = act;
		s_axis_tdata = {7'd0, lerr, tval, cmd};
		s_axis_tvalid = 1'b1;
		do
			@(posedge clk);
		while (!s_axis_tready);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	task automatic send_tick();
		if ($urandom_range(0, 39) == 0)
			link_down = !link_down;
		send_event(ACT_TICK, 8'($urandom), 16'($urandom),
			link_down || $urandom_range(0, 7) == 0);
	endtask

	task automatic wait_idle();
		while (status_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_register(cfg_idx_t idx, logic [15:0] val);
		wait_idle();
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			CFG_WDT_ENABLE: en_code = val[7:0];
			CFG_TIMER_LIMIT: limit_s = val;
			CFG_CYCLE_DELAY: delay_s = val[7:0];
			default: count_s = val;
		endcase
	endtask

	// cycle_ok clear keeps the watchdog out of a power cycle, which only a reset would end
	task automatic send_random(bit cycle_ok);
		action_t act;
		logic [7:0] cmd;
		logic [15:0] tval;
		int pick;
		pick = $urandom_range(0, 99);
		cmd = 8'($urandom);
		tval = 16'($urandom);
		if (pick < 60)
			act = ACT_TICK;
		else if (pick < 80)
			act = ACT_CMD;
		else if (pick < 90)
			act = ACT_TIMER_WR;
		else
			act = ACT_SAVE_DONE;
		if (act == ACT_CMD) begin
			case ($urandom_range(0, 3))
				0: cmd = CMD_CLEAR;
				1: cmd = CMD_RESET;
				2: cmd = CMD_CYCLE;
				default: ;
			endcase
		end
		if (act == ACT_TIMER_WR && $urandom_range(0, 1) == 1)
			tval = limit_s - 16'($urandom_range(0, 3));
		if (!cycle_ok) begin
			if (act == ACT_CMD && cmd == CMD_CYCLE)
				cmd = CMD_CYCLE ^ (8'h01 << $urandom_range(0, 7));
			if (act == ACT_TICK && en_code == WDT_ENABLE_MAGIC && timer_s >= limit_s) begin
				act = ACT_CMD;
				cmd = CMD_CLEAR;
			end
		end
		if (act == ACT_TICK)
			send_tick();
		else
			send_event(act, cmd, tval, 1'($urandom));
	endtask

	task automatic random_config();
		logic [15:0] lim;
		if ($urandom_range(0, 9) < 6)
			write_register(CFG_WDT_ENABLE, {8'd0, WDT_ENABLE_MAGIC});
		else
			write_register(CFG_WDT_ENABLE, 16'($urandom_range(0, 255)));
		case ($urandom_range(0, 4))
			0: lim = 16'd1;
			1: lim = 16'hFFFF;
			2: lim = 16'($urandom);
			default: lim = 16'($urandom_range(1, 40));
		endcase
		if (en_code != WDT_ENABLE_MAGIC && $urandom_range(0, 3) == 0)
			lim = 16'd0;
		write_register(CFG_TIMER_LIMIT, lim);
		case ($urandom_range(0, 2))
			0: write_register(CFG_CYCLE_DELAY, 16'd0);
			1: write_register(CFG_CYCLE_DELAY, 16'd255);
			default: write_register(CFG_CYCLE_DELAY, 16'($urandom_range(0, 255)));
		endcase
		case ($urandom_range(0, 5))
			0: write_register(CFG_COUNT_INIT, 16'd0);
			1: write_register(CFG_COUNT_INIT, 16'hFFFF);
			2: write_register(CFG_COUNT_INIT, 16'($urandom));
			default: ;
		endcase
	endtask

	task automatic test_directed();
		send_event(ACT_TICK, 8'h00, 16'h0000, 1'b0);
		send_event(ACT_TIMER_WR, 8'hFF, 16'hFFFF, 1'b1);
		send_event(ACT_TIMER_WR, 8'h00, 16'h0000, 1'b0);
		send_event(ACT_CMD, 8'h00, 16'hFFFF, 1'b1);
		send_event(ACT_CMD, 8'hFF, 16'h0000, 1'b0);
		send_event(ACT_CMD, CMD_RESET, 16'h0000, 1'b0);
		send_event(ACT_CMD, CMD_CLEAR, 16'h0000, 1'b0);
		send_event(ACT_SAVE_DONE, 8'h00, 16'h0000, 1'b1);
		// one off the enable code: no counting
		write_register(CFG_WDT_ENABLE, 16'h0062);
		send_event(ACT_TICK, 8'h00, 16'h0000, 1'b0);
		write_register(CFG_COUNT_INIT, 16'hFFFF);
		send_event(ACT_TICK, 8'h00, 16'h0000, 1'b0);
		write_register(CFG_WDT_ENABLE, {8'd0, WDT_ENABLE_MAGIC});
		write_register(CFG_TIMER_LIMIT, 16'hFFFF);
		send_event(ACT_TIMER_WR, 8'h00, 16'hFFFD, 1'b0);
		send_event(ACT_TICK, 8'h00, 16'h0000, 1'b1);
		send_event(ACT_TICK, 8'h00, 16'h0000, 1'b1);
		send_event(ACT_CMD, CMD_CLEAR, 16'hFFFF, 1'b0);
		send_event(ACT_TICK, 8'hFF, 16'hFFFF, 1'b0);
		write_register(CFG_COUNT_INIT, 16'h0000);
		write_register(CFG_WDT_ENABLE, 16'h00FF);
		write_register(CFG_TIMER_LIMIT, 16'h0000);
		write_register(CFG_CYCLE_DELAY, 16'd255);
		send_event(ACT_TIMER_WR, 8'h00, 16'h8000, 1'b0);
		send_event(ACT_TICK, 8'h00, 16'h0000, 1'b0);
		send_event(ACT_CMD, CMD_CYCLE ^ 8'h80, 16'h0000, 1'b0);
	endtask

	task automatic test_random(int items, int sender_pct, int receiver_pct);
		send_idle_pct = sender_pct;
		recv_idle_pct = receiver_pct;
		for (int i = 0; i < items; i++) begin
			if (i % 100 == 0)
				random_config();
			send_random(1'b0);
		end
	endtask

	task automatic test_power_cycle();
		int mode;
		mode = $urandom_range(0, 3);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		if (mode < 2) begin
			cycle_kind = (mode == 0) ? "watchdog expiry with count wrap" : "watchdog expiry";
			write_register(CFG_COUNT_INIT, (mode == 0) ? 16'hFFFF : 16'($urandom));
			write_register(CFG_WDT_ENABLE, {8'd0, WDT_ENABLE_MAGIC});
			write_register(CFG_TIMER_LIMIT, 16'($urandom_range(1, 20)));
			while (!pending_s)
				send_tick();
			repeat (2) begin
				repeat ($urandom_range(0, 5))
					send_tick();
				send_event(ACT_SAVE_DONE, 8'($urandom), 16'($urandom), 1'($urandom));
			end
		end else begin
			cycle_kind = (mode == 2) ? "host command with zero delay" : "host command";
			write_register(CFG_TIMER_LIMIT, 16'($urandom_range(100, 65535)));
			write_register(CFG_CYCLE_DELAY, (mode == 2) ? 16'd0 :
				($urandom_range(0, 3) == 0) ? 16'd255 : 16'($urandom_range(1, 40)));
			send_event(ACT_CMD, CMD_CYCLE, 16'($urandom), 1'($urandom));
		end
		while (!shut_s) begin
			if ($urandom_range(0, 4) == 0)
				send_event(ACT_SAVE_DONE, 8'($urandom), 16'($urandom), 1'($urandom));
			else
				send_tick();
		end
	endtask

	task automatic test_after_shutdown(int items);
		write_register(CFG_WDT_ENABLE, {8'd0, WDT_ENABLE_MAGIC});
		write_register(CFG_TIMER_LIMIT, 16'($urandom_range(0, 30)));
		write_register(CFG_COUNT_INIT, 16'($urandom));
		for (int i = 0; i < items; i++)
			send_random(1'b1);
	endtask

	initial begin
		reset_watchdog_model();
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(500, 25, 58);
		test_random(500, 58, 25);
		test_power_cycle();
		test_after_shutdown(250);
		wait_idle();
		repeat (8) @(negedge clk);
		if (status_due.size() != 0)
			report_mismatch($sformatf("%0d status beats never arrived", status_due.size()));
		$display("%0d events sent, %0d status beats checked, %0d reset pulses expected",
			events_taken, status_checked, pulses_due);
		$display("power cycle by %s, %0d mismatches", cycle_kind, error_count);
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
